[hw/rtl/sorted_key_table_search_delete_assert.svh]
// Assertion macros for the sorted key table.
`ifndef SORTED_KEY_TABLE_SEARCH_DELETE_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_DELETE_ASSERT_SVH

`ifndef SYNTHESIS
`define SKTSD_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sorted key table: same-cycle check failed");
`define SKTSD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sorted key table: next-cycle check failed");
`else
`define SKTSD_ASSERT_NOW(label, clk, rst, pre, post)
`define SKTSD_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

[hw/rtl/sktsd_pkg.sv]
// Types and codes shared by the sorted key table.
`timescale 1ns / 1ps
package sktsd_pkg;

   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_UPDATE = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_READ   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NOT_FOUND = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_RANGE     = 3'd3,
      STATUS_ORDER     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND_CHK,
      ST_SEARCH,
      ST_SEARCH_CHK,
      ST_SHIFT,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      req_code_type req_type;
      logic [30:0]  key;
      logic [15:0]  value_first;
      logic [15:0]  value_second;
      logic [7:0]   read_index;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  entry_index;
      logic [30:0] entry_key;
      logic [15:0] entry_first;
      logic [15:0] entry_second;
      logic [8:0]  entry_count;
   } rsp_item_type;

   typedef struct packed {
      logic [30:0] key;
      logic [15:0] first;
      logic [15:0] second;
   } entry_type;

endpackage

[hw/rtl/sktsd_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module sktsd_ram #(
   parameter int WIDTH = 63,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sorted_key_table_search_delete.sv]
// Sorted key table: append, binary-search update, remove with shift, indexed read.
//
// Usage: drive req_item and raise start; the item is taken at a clock edge where
// start is high and busy is low. Exactly one result follows on rsp_item, valid for
// one cycle while rsp_strobe is high; the receiver cannot stall it. All records sit
// in one memory with a read port and a write port and a registered read.
// Steps from accept to the result strobe (p = hit position):
//   append: answered without a memory read on a full or empty table, else the
//     last key is read and the new key must be greater than it.
//   read: answered without a memory read out of range, else the entry is read.
//   update: a binary search with a memory read per probe; a miss is reported
//     once the search range is empty.
//   remove: the search, then the entries above p move down at one entry per
//     cycle, set by the single write port.
// busy stays high until the result is issued; the next item may be accepted
// in the cycle the strobe is shown.
// Reset clears the entry count and the control state; memory contents are
// left as they are and never read before written.
`timescale 1ns / 1ps
`include "sorted_key_table_search_delete_assert.svh"
module sorted_key_table_search_delete
   import sktsd_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > 9) ? CW : 9;
   localparam int EW = $bits(entry_type);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pend_ff, pend_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   req_item_type  req_ff, req_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   entry_type     hit_ff, hit_in;
   rsp_item_type  rsp_ff, rsp_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   entry_type     ram_wd, ram_rd;
   logic [EW-1:0] ram_rd_bits;

   logic          emit;
   status_type    emit_status;
   logic [XW-1:0] emit_pos;
   entry_type     emit_entry;
   logic [XW-1:0] count_wide;
   logic [XW-1:0] ri_wide;
   logic [XW-1:0] cnt_cmp;
   logic [CW-1:0] count_m1;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid_calc;

   sktsd_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_en  (ram_re),
      .rd_addr(ram_ra),
      .rd_data(ram_rd_bits)
   );

   assign ram_rd   = entry_type'(ram_rd_bits);
   assign count_m1 = count_ff - CW'(1);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[CW:1];
   assign ri_wide  = XW'(req_item.read_index);
   assign cnt_cmp  = XW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pend_in       = 1'b0;
      rsp_strobe_in = 1'b0;
      req_in        = req_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      hit_in        = hit_ff;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_wa        = '0;
      ram_wd        = '0;
      ram_re        = 1'b0;
      ram_ra        = '0;
      emit          = 1'b0;
      emit_status   = STATUS_OK;
      emit_pos      = '0;
      emit_entry    = '0;
      count_wide    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               case (req_item.req_type)
                  REQ_APPEND: begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        emit        = 1'b1;
                        emit_status = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        ram_we     = 1'b1;
                        ram_wa     = '0;
                        ram_wd     = '{key: req_item.key, first: '0, second: '0};
                        count_in   = count_ff + CW'(1);
                        emit       = 1'b1;
                        emit_entry = '{key: req_item.key, first: '0, second: '0};
                     end else begin
                        ram_re   = 1'b1;
                        ram_ra   = count_m1[AW-1:0];
                        state_in = ST_APPEND_CHK;
                     end
                  end
                  REQ_UPDATE, REQ_REMOVE: begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = ST_SEARCH;
                  end
                  REQ_READ: begin
                     if (ri_wide >= cnt_cmp) begin
                        emit        = 1'b1;
                        emit_status = STATUS_RANGE;
                     end else begin
                        ram_re   = 1'b1;
                        ram_ra   = ri_wide[AW-1:0];
                        state_in = ST_READ_OUT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_APPEND_CHK: begin
            emit = 1'b1;
            if (req_ff.key <= ram_rd.key) begin
               emit_status = STATUS_ORDER;
            end else begin
               ram_we     = 1'b1;
               ram_wa     = count_ff[AW-1:0];
               ram_wd     = '{key: req_ff.key, first: '0, second: '0};
               count_in   = count_ff + CW'(1);
               emit_pos   = XW'(count_ff);
               emit_entry = '{key: req_ff.key, first: '0, second: '0};
            end
         end
         ST_SEARCH: begin
            if (lo_ff >= hi_ff) begin
               emit        = 1'b1;
               emit_status = STATUS_NOT_FOUND;
            end else begin
               mid_in   = mid_calc;
               ram_re   = 1'b1;
               ram_ra   = mid_calc[AW-1:0];
               state_in = ST_SEARCH_CHK;
            end
         end
         ST_SEARCH_CHK: begin
            if (ram_rd.key == req_ff.key) begin
               if (req_ff.req_type == REQ_UPDATE) begin
                  ram_we     = 1'b1;
                  ram_wa     = mid_ff[AW-1:0];
                  ram_wd     = '{key: req_ff.key, first: req_ff.value_first,
                                 second: req_ff.value_second};
                  emit       = 1'b1;
                  emit_pos   = XW'(mid_ff);
                  emit_entry = '{key: req_ff.key, first: req_ff.value_first,
                                 second: req_ff.value_second};
               end else begin
                  hit_in   = ram_rd;
                  src_in   = mid_ff + CW'(1);
                  dst_in   = mid_ff[AW-1:0];
                  state_in = ST_SHIFT;
               end
            end else if (ram_rd.key > req_ff.key) begin
               hi_in    = mid_ff;
               state_in = ST_SEARCH;
            end else begin
               lo_in    = mid_ff + CW'(1);
               state_in = ST_SEARCH;
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               ram_we = 1'b1;
               ram_wa = dst_ff;
               ram_wd = ram_rd;
               dst_in = dst_ff + AW'(1);
            end
            if (src_ff < count_ff) begin
               ram_re  = 1'b1;
               ram_ra  = src_ff[AW-1:0];
               src_in  = src_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               count_in   = count_m1;
               emit       = 1'b1;
               emit_pos   = XW'(mid_ff);
               emit_entry = hit_ff;
            end
         end
         ST_READ_OUT: begin
            emit       = 1'b1;
            emit_pos   = XW'(req_ff.read_index);
            emit_entry = ram_rd;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         state_in            = ST_IDLE;
         rsp_strobe_in       = 1'b1;
         count_wide          = XW'(count_in);
         rsp_in.status       = emit_status;
         rsp_in.entry_index  = emit_pos[7:0];
         rsp_in.entry_key    = emit_entry.key;
         rsp_in.entry_first  = emit_entry.first;
         rsp_in.entry_second = emit_entry.second;
         rsp_in.entry_count  = count_wide[8:0];
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `SKTSD_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)
   `SKTSD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH))
   `SKTSD_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE)

endmodule
